// ===== rtl/core/rrw_pkg.sv =====
// Package for the rate rescaling watchdog: data width, request codes,
// sequencer states and the divider status struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrw_pkg;

	localparam int W = 32;
	localparam int CNT_W = $clog2(W);

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_KICK    = 2'd1,
		REQ_SET_TMO = 2'd2,
		REQ_INIT    = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV1,
		ST_MULQ,
		ST_MULR,
		ST_DIV2S,
		ST_DIV2,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/rrw_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rrw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rrw_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [rrw_pkg::W-1:0] dividend,
	input  wire logic [rrw_pkg::W-1:0] divisor,
	output rrw_pkg::div_sts_t         sts,
	output logic [rrw_pkg::W-1:0]     quotient,
	output logic [rrw_pkg::W-1:0]     remainder
);

	logic [rrw_pkg::W-1:0]     rem_q;
	logic [rrw_pkg::W-1:0]     quo_q;
	logic [rrw_pkg::W-1:0]     dsr_q;
	logic [rrw_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [rrw_pkg::W:0]       rem_sh;
	logic                      fits;

	// remainder stays below divisor, so the shifted value needs one extra bit
	assign rem_sh = {rem_q, quo_q[rrw_pkg::W-1]};
	assign fits   = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rrw_pkg::CNT_W'(rrw_pkg::W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rrw_pkg::W'(rem_sh - {1'b0, dsr_q});
			end else begin
				rem_q <= rem_sh[rrw_pkg::W-1:0];
			end
			quo_q <= {quo_q[rrw_pkg::W-2:0], fits};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

// ===== rtl/core/rate_rescaling_watchdog.sv =====
// Rate rescaling watchdog top level: request sequencer, state, multiplier
// and output register. Depends on rrw_pkg and rrw_div.
// Sequence: kick, set-timeout, init and non-rescaling ticks pass from the
// accepted item through EVAL and WRITE; a tick that rescales also passes
// through DIV1, MULQ, MULR, DIV2S and DIV2, making two passes through the divider.
// One item at a time, and WRITE waits while the output register is held; req_stall is high from
// acceptance until the result is loaded into the output register. Reset clears all watchdog state.
`timescale 1ns / 1ps
`default_nettype none
module rate_rescaling_watchdog (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// request channel
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic [1:0]            req_type,
	input  wire logic [rrw_pkg::W-1:0] now_ticks,
	input  wire logic [rrw_pkg::W-1:0] tick_rate,
	input  wire logic [rrw_pkg::W-1:0] new_timeout,
	// response channel
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output logic                       tripped,
	output logic [rrw_pkg::W-1:0]      elapsed_ticks,
	output logic [rrw_pkg::W-1:0]      timeout_now,
	output logic                       is_armed
);

	localparam int W = rrw_pkg::W;

	rrw_pkg::state_t    state_q, state_d;

	// latched request
	rrw_pkg::req_type_t req_q;
	logic [W-1:0]       now_q;
	logic [W-1:0]       rate_q;
	logic [W-1:0]       nto_q;

	// watchdog state
	logic [W-1:0]       timeout_q;
	logic [W-1:0]       last_kick_q;
	logic               armed_q;
	logic [W-1:0]       ref_rate_q;

	// rescale datapath
	logic               rescale_q;
	logic [W-1:0]       whole_q;
	logic [W-1:0]       mul_q;
	logic [W-1:0]       mul_a;
	logic [W-1:0]       mul_full;
	logic [W-1:0]       res_sum;

	// divider hookup
	logic               div_start;
	logic [W-1:0]       div_dividend;
	rrw_pkg::div_sts_t  div_sts;
	logic [W-1:0]       div_quo;
	logic [W-1:0]       div_rem;

	// commit values
	logic               commit;
	logic               accept;
	logic               active_tick;
	logic               need_rescale;
	logic [W-1:0]       nxt_to;
	logic [W-1:0]       nxt_last;
	logic               nxt_armed;
	logic [W-1:0]       nxt_ref;
	logic [W-1:0]       nxt_elapsed;
	logic               nxt_trip;

	// response register
	logic               rsp_valid_q;
	logic               trip_q;
	logic [W-1:0]       elapsed_q;
	logic [W-1:0]       tmo_out_q;
	logic               armed_out_q;

	rrw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (ref_rate_q),
		.sts       (div_sts),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign accept = req_valid && !req_stall;

	// a tick on an armed watchdog with a live timeout
	assign active_tick  = (req_q == rrw_pkg::REQ_TICK) && armed_q && (timeout_q != '0);
	assign need_rescale = active_tick && (rate_q != '0) && (ref_rate_q != '0)
		&& (rate_q != ref_rate_q);

	// shared multiplier: first quotient * rate, then remainder * rate; wraps at W bits
	assign mul_a    = (state_q == rrw_pkg::ST_MULQ) ? div_quo : div_rem;
	assign mul_full = mul_a * rate_q;
	assign res_sum  = whole_q + div_quo;

	always_ff @(posedge clk) begin
		mul_q <= mul_full;
		if (state_q == rrw_pkg::ST_MULR) begin
			whole_q <= mul_q;
		end
		if (accept) begin
			req_q  <= rrw_pkg::req_type_t'(req_type);
			now_q  <= now_ticks;
			rate_q <= tick_rate;
			nto_q  <= new_timeout;
		end
	end

	// rescaled timeout lands in rescale path; zero becomes one
	logic [W-1:0] res_to_q;
	always_ff @(posedge clk) begin
		if (state_q == rrw_pkg::ST_DIV2 && div_sts.done) begin
			res_to_q <= (res_sum == '0) ? W'(1) : res_sum;
		end
	end

	// next watchdog state from the latched request
	always_comb begin
		nxt_to    = timeout_q;
		nxt_last  = last_kick_q;
		nxt_armed = armed_q;
		nxt_ref   = ref_rate_q;
		unique case (req_q)
			rrw_pkg::REQ_INIT: begin
				nxt_to    = nto_q;
				nxt_last  = now_q;
				nxt_armed = (nto_q != '0);
				nxt_ref   = rate_q;
			end
			rrw_pkg::REQ_SET_TMO: begin
				nxt_to = nto_q;
				if (nto_q == '0) begin
					nxt_armed = 1'b0;
				end else begin
					nxt_armed = 1'b1;
					nxt_last  = now_q;
				end
			end
			rrw_pkg::REQ_KICK: begin
				nxt_last = now_q;
			end
			rrw_pkg::REQ_TICK: begin
				if (rescale_q) begin
					nxt_to  = res_to_q;
					nxt_ref = rate_q;
				end
			end
			default: ;
		endcase
		nxt_elapsed = now_q - nxt_last;
		nxt_trip    = active_tick && (nxt_elapsed >= nxt_to);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_stall    = 1'b1;
		div_start    = 1'b0;
		div_dividend = timeout_q;
		commit       = 1'b0;
		unique case (state_q)
			rrw_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = rrw_pkg::ST_EVAL;
				end
			end
			rrw_pkg::ST_EVAL: begin
				if (need_rescale) begin
					div_start = 1'b1;
					state_d   = rrw_pkg::ST_DIV1;
				end else begin
					state_d = rrw_pkg::ST_WRITE;
				end
			end
			rrw_pkg::ST_DIV1: begin
				if (div_sts.done) begin
					state_d = rrw_pkg::ST_MULQ;
				end
			end
			rrw_pkg::ST_MULQ: begin
				state_d = rrw_pkg::ST_MULR;
			end
			rrw_pkg::ST_MULR: begin
				state_d = rrw_pkg::ST_DIV2S;
			end
			rrw_pkg::ST_DIV2S: begin
				div_start    = 1'b1;
				div_dividend = mul_q;
				state_d      = rrw_pkg::ST_DIV2;
			end
			rrw_pkg::ST_DIV2: begin
				if (div_sts.done) begin
					state_d = rrw_pkg::ST_WRITE;
				end
			end
			rrw_pkg::ST_WRITE: begin
				// wait only while an older item still sits in the output register
				if (!rsp_valid_q || !rsp_stall) begin
					commit  = 1'b1;
					state_d = rrw_pkg::ST_IDLE;
				end
			end
			default: state_d = rrw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rescale_q <= 1'b0;
		end else if (state_q == rrw_pkg::ST_EVAL) begin
			rescale_q <= need_rescale;
		end
	end

	// watchdog state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= '0;
			last_kick_q <= '0;
			armed_q     <= 1'b0;
			ref_rate_q  <= '0;
		end else if (commit) begin
			timeout_q   <= nxt_to;
			last_kick_q <= nxt_last;
			armed_q     <= nxt_armed;
			ref_rate_q  <= nxt_ref;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			trip_q      <= nxt_trip;
			elapsed_q   <= nxt_elapsed;
			tmo_out_q   <= nxt_to;
			armed_out_q <= nxt_armed;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign tripped       = trip_q;
	assign elapsed_ticks = elapsed_q;
	assign timeout_now   = tmo_out_q;
	assign is_armed      = armed_out_q;

endmodule
`default_nettype wire

// ===== rtl/core/rrw_checker.sv =====
// Port-level checks for the rate rescaling watchdog, bound to the top level.
// Depends on rrw_pkg and rate_rescaling_watchdog.
`timescale 1ns / 1ps
`default_nettype none
module rrw_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  req_valid,
	input wire logic                  req_stall,
	input wire logic                  rsp_valid,
	input wire logic                  rsp_stall,
	input wire logic                  tripped,
	input wire logic [rrw_pkg::W-1:0] elapsed_ticks,
	input wire logic [rrw_pkg::W-1:0] timeout_now,
	input wire logic                  is_armed
);

	// a held result item does not change
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(tripped)
			&& $stable(elapsed_ticks) && $stable(timeout_now) && $stable(is_armed))
		else $error("held response changed");

	// one item at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while busy");

	a_trip_armed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && tripped |-> is_armed)
		else $error("trip while disarmed");

	a_trip_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && tripped |-> (timeout_now != '0) && (elapsed_ticks >= timeout_now))
		else $error("trip below timeout");

endmodule

bind rate_rescaling_watchdog rrw_checker u_rrw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_stall     (req_stall),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.tripped       (tripped),
	.elapsed_ticks (elapsed_ticks),
	.timeout_now   (timeout_now),
	.is_armed      (is_armed)
);
`default_nettype wire
